// File: rtl/tfbc_pkg.sv
package tfbc_pkg;

  localparam int unsigned BlockW = 12;
  localparam int unsigned HalfW  = 6;
  localparam int unsigned KeyW   = 9;
  localparam int unsigned RoundW = 5;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [HalfW-1:0]  half_t;
  typedef logic [KeyW-1:0]   key_t;

  // cipher controls handed from the top level to the round chain
  typedef struct packed {
    key_t              key;
    logic [RoundW-1:0] rounds;
    logic              dec;
  } tfbc_ctl_t;

  typedef logic [2:0] sbox_entry_t;
  localparam sbox_entry_t SBOX_ONE [16] = '{
    3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
    3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3
  };
  localparam sbox_entry_t SBOX_TWO [16] = '{
    3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
    3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4
  };

  // top 8 bits of the key rotated left by rot (rot below KeyW)
  function automatic logic [7:0] round_key(input key_t key, input int unsigned rot);
    logic [2*KeyW-1:0] dbl;
    dbl = {key, key} << rot;
    return dbl[2*KeyW-1:KeyW+1];
  endfunction

  // round function: expand 0,1,3,2,3,2,4,5 (bit 0 is msb), key mix, two s-boxes
  function automatic half_t mix(input half_t r, input logic [7:0] k8);
    logic [7:0] e;
    e = {r[5], r[4], r[2], r[3], r[2], r[3], r[1], r[0]} ^ k8;
    return {SBOX_ONE[e[7:4]], SBOX_TWO[e[3:0]]};
  endfunction

endpackage

// File: rtl/toy_feistel_block_cipher_modes.sv
// 12-bit toy feistel block cipher with ecb, cbc and ctr chaining. each word on
// s_tdata is one block and gives exactly one block on m_tdata, in order. the
// block takes one word per clock cycle while m_tready is high; each block passes
// the input register, then the result register. all cipher rounds (up to
// MAX_ROUNDS) are laid out between those two registers, so the chain register
// feeding cbc and ctr is updated in the same cycle the block moves on and the
// next block can follow right behind. the result register lets a new word in
// while a finished one waits for m_tready. configuration goes over the cfg
// channel (index 0 key, 1 round count, 2 mode, 3 decrypt, 4 iv) and is always
// ready; write only while no block is in flight. writing the iv reloads the
// chain register. mode code 3 behaves as ecb, a round count above MAX_ROUNDS
// runs MAX_ROUNDS rounds, writes to indexes above 4 are dropped.
module toy_feistel_block_cipher_modes #(
  parameter int unsigned MAX_ROUNDS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [11:0] data_block, [15:12] zero
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [11:0] result_block, [15:12] zero
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import tfbc_pkg::*;

  typedef enum logic [2:0] {
    REG_KEY    = 3'd0,
    REG_ROUNDS = 3'd1,
    REG_MODE   = 3'd2,
    REG_DEC    = 3'd3,
    REG_IV     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_ECB = 2'd0,
    MODE_CBC = 2'd1,
    MODE_CTR = 2'd2,
    MODE_ALT = 2'd3
  } mode_t;

  localparam block_t IvReset = 12'hF0F;

  // configuration registers
  key_t              cipher_key;
  logic [RoundW-1:0] round_count;
  mode_t             chain_mode;
  logic              decrypt_select;

  // chain register: cbc feedback or ctr counter
  block_t chain_value;
  block_t chain_value_next;

  // input and result registers
  logic   in_valid;
  block_t in_block;
  logic   out_valid;
  block_t out_block;

  logic      advance;
  logic      in_take;
  tfbc_ctl_t ctl;
  block_t    core_in;
  block_t    core_out;
  block_t    result;

  assign cfg_ready = 1'b1;

  // input register moves on whenever the result register is free or drains
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign in_take  = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_block};

  // cipher direction: ctr always encrypts the counter
  always_comb begin
    ctl.key    = cipher_key;
    ctl.rounds = round_count;
    ctl.dec    = decrypt_select && (chain_mode != MODE_CTR);
  end

  // what goes into the cipher for each mode
  always_comb begin
    core_in = in_block;
    case (chain_mode)
      MODE_CBC: begin
        if (!decrypt_select) begin
          core_in = in_block ^ chain_value;
        end
      end
      MODE_CTR: begin
        core_in = chain_value;
      end
      default: begin
        // ecb, also for the unused mode code
      end
    endcase
  end

  // mode steering after the cipher
  always_comb begin
    result           = core_out;
    chain_value_next = chain_value;
    case (chain_mode)
      MODE_CBC: begin
        if (decrypt_select) begin
          result           = core_out ^ chain_value;
          chain_value_next = in_block;
        end else begin
          chain_value_next = core_out;
        end
      end
      MODE_CTR: begin
        result           = in_block ^ core_out;
        chain_value_next = chain_value + 12'd1;
      end
      default: begin
        // ecb, also for the unused mode code
      end
    endcase
  end

  tfbc_core #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_core (
    .ctl     (ctl),
    .blk_in  (core_in),
    .blk_out (core_out)
  );

  // configuration and chain state
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key     <= 9'd1;
      round_count    <= 5'd4;
      chain_mode     <= MODE_ECB;
      decrypt_select <= 1'b0;
      chain_value    <= IvReset;
    end else begin
      if (advance) begin
        chain_value <= chain_value_next;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_KEY:    cipher_key     <= cfg_data[KeyW-1:0];
          REG_ROUNDS: round_count    <= cfg_data[RoundW-1:0];
          REG_MODE:   chain_mode     <= mode_t'(cfg_data[1:0]);
          REG_DEC:    decrypt_select <= cfg_data[0];
          REG_IV:     chain_value    <= cfg_data;
          default: begin
            // unmapped index, dropped
          end
        endcase
      end
    end
  end

  // datapath handshake registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_block <= s_tdata[BlockW-1:0];
    end
    if (advance) begin
      out_block <= result;
    end
  end

endmodule

// File: rtl/tfbc_round.sv
module tfbc_round #(
  parameter int unsigned STAGE      = 1,
  parameter int unsigned MAX_ROUNDS = 16,
  parameter int unsigned RW         = 5
) (
  input  tfbc_pkg::tfbc_ctl_t ctl,
  input  logic [RW-1:0]       active,
  input  tfbc_pkg::half_t     l_in,
  input  tfbc_pkg::half_t     r_in,
  output tfbc_pkg::half_t     l_out,
  output tfbc_pkg::half_t     r_out
);
  import tfbc_pkg::*;

  // decryption walks the same chain with the round numbers reversed
  localparam int unsigned EncNum = STAGE;
  localparam int unsigned DecNum = MAX_ROUNDS + 1 - STAGE;
  localparam int unsigned EncRot = EncNum % 9;
  localparam int unsigned DecRot = DecNum % 9;
  localparam logic [RW-1:0] EncIdx = RW'(EncNum);
  localparam logic [RW-1:0] DecIdx = RW'(DecNum);

  logic [7:0] k8;
  logic       en;

  always_comb begin
    if (ctl.dec) begin
      k8 = round_key(ctl.key, DecRot);
      en = (DecIdx <= active);
    end else begin
      k8 = round_key(ctl.key, EncRot);
      en = (EncIdx <= active);
    end
  end

  always_comb begin
    if (en) begin
      l_out = r_in;
      r_out = l_in ^ mix(r_in, k8);
    end else begin
      l_out = l_in;
      r_out = r_in;
    end
  end

endmodule

// File: rtl/tfbc_core.sv
module tfbc_core #(
  parameter int unsigned MAX_ROUNDS = 16
) (
  input  tfbc_pkg::tfbc_ctl_t ctl,
  input  tfbc_pkg::block_t    blk_in,
  output tfbc_pkg::block_t    blk_out
);
  import tfbc_pkg::*;

  localparam int unsigned RW = $clog2(MAX_ROUNDS + 1);
  localparam int unsigned CW = (RW > RoundW) ? RW : RoundW;

  logic [CW-1:0] rounds_ext;
  logic [RW-1:0] active;
  half_t         l_s [MAX_ROUNDS+1];
  half_t         r_s [MAX_ROUNDS+1];

  // saturate the round count at the number of built rounds
  assign rounds_ext = CW'(ctl.rounds);
  assign active = (rounds_ext > CW'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : RW'(rounds_ext);

  // decryption is encryption on swapped halves with reversed keys
  assign l_s[0] = ctl.dec ? blk_in[HalfW-1:0]      : blk_in[BlockW-1:HalfW];
  assign r_s[0] = ctl.dec ? blk_in[BlockW-1:HalfW] : blk_in[HalfW-1:0];

  for (genvar s = 1; s <= MAX_ROUNDS; s++) begin : g_round
    tfbc_round #(
      .STAGE      (s),
      .MAX_ROUNDS (MAX_ROUNDS),
      .RW         (RW)
    ) u_round (
      .ctl    (ctl),
      .active (active),
      .l_in   (l_s[s-1]),
      .r_in   (r_s[s-1]),
      .l_out  (l_s[s]),
      .r_out  (r_s[s])
    );
  end

  assign blk_out = ctl.dec ? {r_s[MAX_ROUNDS], l_s[MAX_ROUNDS]}
                           : {l_s[MAX_ROUNDS], r_s[MAX_ROUNDS]};

endmodule
